@@ rtl/core/hpt_pkg.sv @@
// hpt_pkg: shared types, constants and helper functions for the hashed path table lookup
// no dependencies; imported by the top level hashed_path_table_lookup
package hpt_pkg;

  localparam int unsigned TableDepth   = 262144;
  localparam int unsigned AddrW        = $clog2(TableDepth);
  localparam int unsigned CountW       = $clog2(TableDepth + 1);
  localparam int unsigned MaxPathBytes = 1023;
  localparam int unsigned PathLenW     = $clog2(MaxPathBytes + 1);

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  localparam logic [7:0] CharSlash     = 8'h2F;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharUpperA    = 8'h41;
  localparam logic [7:0] CharUpperZ    = 8'h5A;
  localparam logic [7:0] CaseOffset    = 8'd32;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_PATH   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_e;

  // one table row as held in memory
  typedef struct packed {
    logic [31:0] hash;
    logic [15:0] file_id;
    logic [31:0] offset;
    logic [31:0] size;
    logic [31:0] full_size;
    logic        flag;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  function automatic logic [7:0] normalize_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (r == CharSlash) r = CharBackslash;
    if (r >= CharUpperA && r <= CharUpperZ) r = r + CaseOffset;
    return r;
  endfunction

  // reflected crc-32, one byte, eight shift steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/hpt_in_if.sv @@
// hpt_in_if: input channel, one beat per command (clear, append or path byte)
// standalone; valid/ready handshake with the payload fields
interface hpt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  path_byte;
  logic        path_last;
  logic [31:0] entry_hash;
  logic [15:0] entry_file_id;
  logic [31:0] entry_offset;
  logic [31:0] entry_size;
  logic [31:0] entry_real_size;
  logic        entry_flag;

  modport source (
    output valid, kind, path_byte, path_last, entry_hash, entry_file_id,
           entry_offset, entry_size, entry_real_size, entry_flag,
    input  ready
  );
  modport sink (
    input  valid, kind, path_byte, path_last, entry_hash, entry_file_id,
           entry_offset, entry_size, entry_real_size, entry_flag,
    output ready
  );
endinterface

@@ rtl/core/hpt_out_if.sv @@
// hpt_out_if: result channel, one beat per looked-up path
// standalone; valid/ready handshake with the payload fields
interface hpt_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] path_hash;
  logic [15:0] hit_file_id;
  logic [31:0] hit_offset;
  logic [31:0] hit_size;
  logic [31:0] hit_real_size;
  logic        hit_flag;
  logic        table_overflow;

  modport source (
    output valid, found, path_hash, hit_file_id, hit_offset, hit_size,
           hit_real_size, hit_flag, table_overflow,
    input  ready
  );
  modport sink (
    input  valid, found, path_hash, hit_file_id, hit_offset, hit_size,
           hit_real_size, hit_flag, table_overflow,
    output ready
  );
endinterface

@@ rtl/core/hashed_path_table_lookup.sv @@
// hashed_path_table_lookup: hash-sorted asset table with crc-32 path hashing and binary search
// clear, append and non-final path beats are taken in the idle state and give no result
// final path beat: a binary search of at most 19 probes (ram read in S_PROBE, compare in S_CMP)
// then S_DONE queues the result; throughput: one beat per cycle except during a search, which
// holds the single ram read port and its compare; input is stalled until the result is queued
// reset clears count, overflow and hash state; table contents stay undefined, no clearing pass
module hashed_path_table_lookup
  import hpt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  hpt_in_if.sink    in_i,
  hpt_out_if.source out_o
);

  state_e              state_q, state_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [31:0]         last_hash_q, last_hash_d;
  logic                overflow_q, overflow_d;
  logic [31:0]         crc_q, crc_d;
  logic [PathLenW-1:0] len_q, len_d;
  logic                ended_q, ended_d;
  logic [31:0]         target_q, target_d;
  logic [CountW-1:0]   lo_q, lo_d;
  logic [CountW-1:0]   hi1_q, hi1_d;
  logic [CountW-1:0]   mid_q, mid_d;
  logic                found_q, found_d;
  logic                out_valid_q, out_valid_d;
  logic                out_load;

  logic                in_fire;
  logic                ram_we;
  logic                ram_re;
  entry_t              ram_wdata;
  entry_t              ram_rdata;
  logic [CountW-1:0]   mid_c;

  entry_t              hit_q;
  logic                out_found_q;
  logic [31:0]         out_hash_q;
  logic                out_ovf_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;

  // hi1 is one past the upper bound, so the search range is empty when lo == hi1
  assign mid_c = lo_q + ((hi1_q - lo_q - CountW'(1)) >> 1);

  assign ram_wdata = '{
    hash:      in_i.entry_hash,
    file_id:   in_i.entry_file_id,
    offset:    in_i.entry_offset,
    size:      in_i.entry_size,
    full_size: in_i.entry_real_size,
    flag:      in_i.entry_flag
  };

  hpt_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (mid_c[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    logic [31:0]         crc_v;
    logic [PathLenW-1:0] len_v;
    logic                ended_v;

    state_d     = state_q;
    count_d     = count_q;
    last_hash_d = last_hash_q;
    overflow_d  = overflow_q;
    crc_d       = crc_q;
    len_d       = len_q;
    ended_d     = ended_q;
    target_d    = target_q;
    lo_d        = lo_q;
    hi1_d       = hi1_q;
    mid_d       = mid_q;
    found_d     = found_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    out_load    = 1'b0;
    crc_v       = crc_q;
    len_v       = len_q;
    ended_v     = ended_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_i.kind)
            KIND_CLEAR: begin
              count_d    = '0;
              overflow_d = 1'b0;
            end
            KIND_APPEND: begin
              if (count_q != '0 && last_hash_q == in_i.entry_hash) begin
                // duplicate of the last stored hash is dropped silently
              end else if (count_q == CountW'(TableDepth)) begin
                overflow_d = 1'b1;
              end else begin
                ram_we      = 1'b1;
                count_d     = count_q + CountW'(1);
                last_hash_d = in_i.entry_hash;
              end
            end
            KIND_PATH: begin
              if (!ended_q) begin
                if (in_i.path_byte == 8'd0) begin
                  ended_v = 1'b1;
                end else if (len_q < PathLenW'(MaxPathBytes)) begin
                  crc_v = crc_byte(crc_q, normalize_char(in_i.path_byte));
                  len_v = len_q + PathLenW'(1);
                end
              end
              if (in_i.path_last) begin
                target_d = ~crc_v;
                crc_d    = CrcInit;
                len_d    = '0;
                ended_d  = 1'b0;
                lo_d     = '0;
                hi1_d    = count_q;
                found_d  = 1'b0;
                state_d  = S_PROBE;
              end else begin
                crc_d   = crc_v;
                len_d   = len_v;
                ended_d = ended_v;
              end
            end
            default: ;
          endcase
        end
      end
      S_PROBE: begin
        if (lo_q < hi1_q) begin
          ram_re  = 1'b1;
          mid_d   = mid_c;
          state_d = S_CMP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CMP: begin
        if (ram_rdata.hash == target_q) begin
          found_d = 1'b1;
          state_d = S_DONE;
        end else if (ram_rdata.hash < target_q) begin
          lo_d    = mid_q + CountW'(1);
          state_d = S_PROBE;
        end else begin
          hi1_d   = mid_q;
          state_d = S_PROBE;
        end
      end
      S_DONE: begin
        // read data is held since no read is issued here
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = (out_valid_q & ~out_o.ready) | out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      overflow_q  <= 1'b0;
      crc_q       <= CrcInit;
      len_q       <= '0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      overflow_q  <= overflow_d;
      crc_q       <= crc_d;
      len_q       <= len_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_hash_q <= last_hash_d;
    target_q    <= target_d;
    lo_q        <= lo_d;
    hi1_q       <= hi1_d;
    mid_q       <= mid_d;
    found_q     <= found_d;
    if (out_load) begin
      out_found_q <= found_q;
      out_hash_q  <= target_q;
      out_ovf_q   <= overflow_q;
      hit_q       <= found_q ? ram_rdata : '0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.found          = out_found_q;
  assign out_o.path_hash      = out_hash_q;
  assign out_o.hit_file_id    = hit_q.file_id;
  assign out_o.hit_offset     = hit_q.offset;
  assign out_o.hit_size       = hit_q.size;
  assign out_o.hit_real_size  = hit_q.full_size;
  assign out_o.hit_flag       = hit_q.flag;
  assign out_o.table_overflow = out_ovf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(TableDepth))
    else $error("entry count beyond table depth");

  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE || state_q == S_CMP) |-> (lo_q <= hi1_q && hi1_q <= count_q))
    else $error("search bounds out of order");

  a_mid_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (mid_q >= lo_q && mid_q < hi1_q))
    else $error("probe index outside search range");

  a_no_write_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_IDLE))
    else $error("table written during a search");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");

endmodule

@@ rtl/core/hpt_ram.sv @@
// hpt_ram: generic single-port-write, single-port-read ram with registered read data
// no dependencies; contents undefined after reset
module hpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
